// ===== hw/rtl/ecgmf_pkg.sv =====
package ecgmf_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 12;   // raw sample and opening/closing values
    localparam int RES_W       = 13;   // residue after baseline removal
    localparam int BR_W        = 14;   // weighted dilation / erosion values
    localparam int SUM_W       = 15;   // sum of the two branches
    localparam int OUT_W       = 14;   // filtered result
    localparam int CFG_W       = 4;    // element weight registers
    localparam int CFG_AW      = 2;    // register index
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_IDX_CENTER = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IDX_SIDE   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_IDX_EDGE   = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] CENTER_RST = 4'd5;
    localparam logic [CFG_W-1:0] SIDE_RST   = 4'd1;
    localparam logic [CFG_W-1:0] EDGE_RST   = 4'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RES_W-1:0]    residue_t;
    typedef logic signed [BR_W-1:0]     branch_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [CFG_W-1:0]    weight_t;

endpackage

// ===== hw/rtl/ecg_morphological_filter.sv =====
// ECG morphological filter. One 12-bit signed sample goes in per item; the
// baseline (flat opening over OPEN_LEN, then flat closing over CLOSE_LEN) is
// subtracted from the sample delayed to line up, and the residue is cleaned
// by averaging a weighted-dilation/flat-erosion branch with a
// weighted-erosion/flat-dilation branch over NOISE_LEN taps (five-tap element:
// edge, side, center, side, edge; weights set by registers 0..2). No result
// comes out until all delay lines have filled: the first
// 2*OPEN_LEN + 2*CLOSE_LEN + 2*NOISE_LEN - 6 items (128 at defaults) give none,
// after that every item gives exactly one. Each accepted item is stored in
// the alignment line, pushed through the four baseline lines in turn, then
// turned into a residue, branch values and a result in the output register;
// items in the fill phase stop early and go back to idle. The time per item
// is dominated by one min/max comparator that walks every tap of the four
// baseline lines, one read a cycle through the single read port of the
// shared line memory. s_tready is high only while the block is idle; a
// finished result waits in the output register, so the next item is taken
// while it waits.
module ecg_morphological_filter #(
    parameter int OPEN_LEN  = 25,
    parameter int CLOSE_LEN = 37,
    parameter int NOISE_LEN = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ecgmf_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] sample
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ecgmf_pkg::M_TDATA_W-1:0]     m_tdata,   // [13:0] filtered
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [ecgmf_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [ecgmf_pkg::CFG_W-1:0]         cfg_wdata
);

    // ------------------------------------------------------------------
    // Derived geometry
    // ------------------------------------------------------------------
    localparam int OPEN_AHEAD  = OPEN_LEN - 1 - (OPEN_LEN - 1) / 2;
    localparam int CLOSE_AHEAD = CLOSE_LEN - 1 - (CLOSE_LEN - 1) / 2;
    localparam int NOISE_HALF  = (NOISE_LEN - 1) / 2;
    localparam int ALIGN_DEPTH = 2 * OPEN_AHEAD + 2 * CLOSE_AHEAD + 1;

    // item count at which each stage starts to produce
    localparam int T_OPEN_ERO  = OPEN_LEN;
    localparam int T_OPEN_DIL  = T_OPEN_ERO + OPEN_LEN - 1;
    localparam int T_CLOSE_DIL = T_OPEN_DIL + CLOSE_LEN - 1;
    localparam int T_CLOSE_ERO = T_CLOSE_DIL + CLOSE_LEN - 1;
    localparam int T_BRANCH    = T_CLOSE_ERO + NOISE_LEN - 1;
    localparam int FILL_DONE   = T_BRANCH + NOISE_LEN - 1;
    localparam int FW          = $clog2(FILL_DONE + 1);

    // shared line memory: four baseline lines and the raw alignment line
    localparam int BASE0      = 0;
    localparam int BASE1      = OPEN_LEN;
    localparam int BASE2      = 2 * OPEN_LEN;
    localparam int BASE3      = 2 * OPEN_LEN + CLOSE_LEN;
    localparam int ALIGN_BASE = 2 * OPEN_LEN + 2 * CLOSE_LEN;
    localparam int MEM_DEPTH  = ALIGN_BASE + ALIGN_DEPTH;
    localparam int AW         = $clog2(MEM_DEPTH);

    localparam int SCAN_MAX = (OPEN_LEN > CLOSE_LEN) ? OPEN_LEN : CLOSE_LEN;
    localparam int KW       = $clog2(SCAN_MAX);
    localparam int NKW      = $clog2(NOISE_LEN);
    localparam int OPW      = $clog2(OPEN_LEN);
    localparam int CPW      = $clog2(CLOSE_LEN);
    localparam int APW      = $clog2(ALIGN_DEPTH);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_AL_RD    = 4'd1;   // fetch oldest raw sample
    localparam logic [3:0] ST_AL_WR    = 4'd2;   // keep it, store new sample
    localparam logic [3:0] ST_WR       = 4'd3;   // push value into a line
    localparam logic [3:0] ST_RD       = 4'd4;   // walk the line
    localparam logic [3:0] ST_DRAIN    = 4'd5;   // last read lands
    localparam logic [3:0] ST_RESID    = 4'd6;   // residue into noise line
    localparam logic [3:0] ST_BR_SCAN  = 4'd7;   // weighted dilation/erosion
    localparam logic [3:0] ST_BR_PUSH  = 4'd8;
    localparam logic [3:0] ST_OUT_SCAN = 4'd9;   // flat erosion/dilation
    localparam logic [3:0] ST_FIN      = 4'd10;  // average, load output

    localparam logic [1:0] STG_OPEN_ERO  = 2'd0;
    localparam logic [1:0] STG_OPEN_DIL  = 2'd1;
    localparam logic [1:0] STG_CLOSE_DIL = 2'd2;
    localparam logic [1:0] STG_CLOSE_ERO = 2'd3;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]      state_reg, state_next;
    logic [1:0]      stg_reg, stg_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [NKW-1:0]  nk_reg, nk_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [OPW-1:0]  open_ptr_reg, open_ptr_next;
    logic [CPW-1:0]  close_ptr_reg, close_ptr_next;
    logic [APW-1:0]  align_ptr_reg, align_ptr_next;
    logic            first_reg, first_next;
    logic            rd_vld_reg;
    logic            m_valid_reg, m_valid_next;

    ecgmf_pkg::sample_t  x_reg, x_next;
    ecgmf_pkg::sample_t  acc_reg, acc_next;
    ecgmf_pkg::sample_t  align_old_reg, align_old_next;
    ecgmf_pkg::branch_t  hi_reg, hi_next;
    ecgmf_pkg::branch_t  lo_reg, lo_next;
    ecgmf_pkg::branch_t  umin_reg, umin_next;
    ecgmf_pkg::branch_t  lmax_reg, lmax_next;
    logic [ecgmf_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    ecgmf_pkg::residue_t res_line_reg [NOISE_LEN];
    ecgmf_pkg::residue_t res_line_next[NOISE_LEN];
    ecgmf_pkg::branch_t  up_line_reg  [NOISE_LEN];
    ecgmf_pkg::branch_t  up_line_next [NOISE_LEN];
    ecgmf_pkg::branch_t  dn_line_reg  [NOISE_LEN];
    ecgmf_pkg::branch_t  dn_line_next [NOISE_LEN];

    ecgmf_pkg::weight_t  center_reg, side_reg, edge_reg;

    // line memory
    ecgmf_pkg::sample_t  mem [MEM_DEPTH];
    ecgmf_pkg::sample_t  rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    ecgmf_pkg::sample_t  mem_wdata;

    // ------------------------------------------------------------------
    // Per-stage selections
    // ------------------------------------------------------------------
    logic [AW-1:0]  region_base;
    logic [KW-1:0]  region_last;
    logic [FW-1:0]  region_gate;
    logic           region_min;
    logic [AW-1:0]  region_ptr;

    always_comb begin
        case (stg_reg)
            STG_OPEN_ERO: begin
                region_base = AW'(BASE0);
                region_last = KW'(OPEN_LEN - 1);
                region_gate = FW'(T_OPEN_ERO);
                region_min  = 1'b1;
            end
            STG_OPEN_DIL: begin
                region_base = AW'(BASE1);
                region_last = KW'(OPEN_LEN - 1);
                region_gate = FW'(T_OPEN_DIL);
                region_min  = 1'b0;
            end
            STG_CLOSE_DIL: begin
                region_base = AW'(BASE2);
                region_last = KW'(CLOSE_LEN - 1);
                region_gate = FW'(T_CLOSE_DIL);
                region_min  = 1'b0;
            end
            default: begin
                region_base = AW'(BASE3);
                region_last = KW'(CLOSE_LEN - 1);
                region_gate = FW'(T_CLOSE_ERO);
                region_min  = 1'b1;
            end
        endcase
    end

    assign region_ptr = stg_reg[1] ? AW'(close_ptr_reg) : AW'(open_ptr_reg);

    // ------------------------------------------------------------------
    // Noise element tap weight for the tap under the scan counter
    // ------------------------------------------------------------------
    logic [NKW-1:0]      tap_dist;
    ecgmf_pkg::weight_t  tap_w;

    always_comb begin
        if (nk_reg >= NKW'(NOISE_HALF)) begin
            tap_dist = nk_reg - NKW'(NOISE_HALF);
        end else begin
            tap_dist = NKW'(NOISE_HALF) - nk_reg;
        end
        if (tap_dist == NKW'(0)) begin
            tap_w = center_reg;
        end else if (tap_dist == NKW'(1)) begin
            tap_w = side_reg;
        end else begin
            tap_w = edge_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared arithmetic
    // ------------------------------------------------------------------
    ecgmf_pkg::residue_t res_tap;
    ecgmf_pkg::branch_t  tap_hi, tap_lo;
    ecgmf_pkg::residue_t residue;
    ecgmf_pkg::sum_t     br_sum, br_sum_adj, br_avg;

    assign res_tap = res_line_reg[nk_reg];
    assign tap_hi  = ecgmf_pkg::branch_t'(res_tap) + ecgmf_pkg::branch_t'(tap_w);
    assign tap_lo  = ecgmf_pkg::branch_t'(res_tap) - ecgmf_pkg::branch_t'(tap_w);
    assign residue = ecgmf_pkg::residue_t'(align_old_reg) - ecgmf_pkg::residue_t'(acc_reg);

    // halve toward zero: add one to negative sums before the shift
    assign br_sum     = ecgmf_pkg::sum_t'(umin_reg) + ecgmf_pkg::sum_t'(lmax_reg);
    assign br_sum_adj = br_sum + ecgmf_pkg::sum_t'(br_sum[ecgmf_pkg::SUM_W-1]);
    assign br_avg     = br_sum_adj >>> 1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        stg_next       = stg_reg;
        k_next         = k_reg;
        nk_next        = nk_reg;
        fill_next      = fill_reg;
        open_ptr_next  = open_ptr_reg;
        close_ptr_next = close_ptr_reg;
        align_ptr_next = align_ptr_reg;
        first_next     = first_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        align_old_next = align_old_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        umin_next      = umin_reg;
        lmax_next      = lmax_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        res_line_next  = res_line_reg;
        up_line_next   = up_line_reg;
        dn_line_next   = dn_line_reg;

        mem_we    = 1'b0;
        mem_waddr = region_base + region_ptr;
        mem_wdata = (stg_reg == STG_OPEN_ERO) ? x_reg : acc_reg;
        mem_raddr = region_base + AW'(k_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // min/max over the data coming back from the memory
        if (rd_vld_reg) begin
            first_next = 1'b0;
            if (first_reg) begin
                acc_next = rdata_reg;
            end else if (region_min) begin
                acc_next = (rdata_reg < acc_reg) ? rdata_reg : acc_reg;
            end else begin
                acc_next = (rdata_reg > acc_reg) ? rdata_reg : acc_reg;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next = ecgmf_pkg::sample_t'(s_tdata[ecgmf_pkg::SAMPLE_W-1:0]);
                    if (fill_reg < FW'(FILL_DONE)) begin
                        fill_next = fill_reg + FW'(1);
                    end
                    open_ptr_next  = (open_ptr_reg == OPW'(OPEN_LEN - 1)) ?
                                     '0 : open_ptr_reg + OPW'(1);
                    close_ptr_next = (close_ptr_reg == CPW'(CLOSE_LEN - 1)) ?
                                     '0 : close_ptr_reg + CPW'(1);
                    align_ptr_next = (align_ptr_reg == APW'(ALIGN_DEPTH - 1)) ?
                                     '0 : align_ptr_reg + APW'(1);
                    state_next = ST_AL_RD;
                end
            end
            ST_AL_RD: begin
                // the slot after the write pointer holds the oldest sample
                // that stays in the line once this item is stored
                mem_raddr  = AW'(ALIGN_BASE) +
                             ((align_ptr_reg == APW'(ALIGN_DEPTH - 1)) ?
                              AW'(0) : AW'(align_ptr_reg) + AW'(1));
                state_next = ST_AL_WR;
            end
            ST_AL_WR: begin
                align_old_next = rdata_reg;
                mem_we         = 1'b1;
                mem_waddr      = AW'(ALIGN_BASE) + AW'(align_ptr_reg);
                mem_wdata      = x_reg;
                stg_next       = STG_OPEN_ERO;
                state_next     = ST_WR;
            end
            ST_WR: begin
                mem_we     = 1'b1;
                first_next = 1'b1;
                k_next     = '0;
                state_next = (fill_reg >= region_gate) ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                if (k_reg == region_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DRAIN: begin
                if (stg_reg == STG_CLOSE_ERO) begin
                    state_next = ST_RESID;
                end else begin
                    stg_next   = stg_reg + 2'd1;
                    state_next = ST_WR;
                end
            end
            ST_RESID: begin
                for (int i = 0; i < NOISE_LEN - 1; i++) begin
                    res_line_next[i] = res_line_reg[i + 1];
                end
                res_line_next[NOISE_LEN - 1] = residue;
                nk_next    = '0;
                state_next = (fill_reg >= FW'(T_BRANCH)) ? ST_BR_SCAN : ST_IDLE;
            end
            ST_BR_SCAN: begin
                if (nk_reg == '0) begin
                    hi_next = tap_hi;
                    lo_next = tap_lo;
                end else begin
                    hi_next = (tap_hi > hi_reg) ? tap_hi : hi_reg;
                    lo_next = (tap_lo < lo_reg) ? tap_lo : lo_reg;
                end
                if (nk_reg == NKW'(NOISE_LEN - 1)) begin
                    state_next = ST_BR_PUSH;
                end else begin
                    nk_next = nk_reg + NKW'(1);
                end
            end
            ST_BR_PUSH: begin
                for (int i = 0; i < NOISE_LEN - 1; i++) begin
                    up_line_next[i] = up_line_reg[i + 1];
                    dn_line_next[i] = dn_line_reg[i + 1];
                end
                up_line_next[NOISE_LEN - 1] = hi_reg;
                dn_line_next[NOISE_LEN - 1] = lo_reg;
                nk_next    = '0;
                state_next = (fill_reg >= FW'(FILL_DONE)) ? ST_OUT_SCAN : ST_IDLE;
            end
            ST_OUT_SCAN: begin
                if (nk_reg == '0) begin
                    umin_next = up_line_reg[nk_reg];
                    lmax_next = dn_line_reg[nk_reg];
                end else begin
                    umin_next = (up_line_reg[nk_reg] < umin_reg) ?
                                up_line_reg[nk_reg] : umin_reg;
                    lmax_next = (dn_line_reg[nk_reg] > lmax_reg) ?
                                dn_line_reg[nk_reg] : lmax_reg;
                end
                if (nk_reg == NKW'(NOISE_LEN - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    nk_next = nk_reg + NKW'(1);
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = br_avg[ecgmf_pkg::OUT_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stg_reg       <= STG_OPEN_ERO;
            k_reg         <= '0;
            nk_reg        <= '0;
            fill_reg      <= '0;
            open_ptr_reg  <= '0;
            close_ptr_reg <= '0;
            align_ptr_reg <= '0;
            first_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stg_reg       <= stg_next;
            k_reg         <= k_next;
            nk_reg        <= nk_next;
            fill_reg      <= fill_next;
            open_ptr_reg  <= open_ptr_next;
            close_ptr_reg <= close_ptr_next;
            align_ptr_reg <= align_ptr_next;
            first_reg     <= first_next;
            rd_vld_reg    <= (state_reg == ST_RD);
            m_valid_reg   <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        align_old_reg <= align_old_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        umin_reg      <= umin_next;
        lmax_reg      <= lmax_next;
        m_data_reg    <= m_data_next;
        res_line_reg  <= res_line_next;
        up_line_reg   <= up_line_next;
        dn_line_reg   <= dn_line_next;
    end

    // line memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= ecgmf_pkg::CENTER_RST;
            side_reg   <= ecgmf_pkg::SIDE_RST;
            edge_reg   <= ecgmf_pkg::EDGE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ecgmf_pkg::CFG_IDX_CENTER: center_reg <= cfg_wdata;
                ecgmf_pkg::CFG_IDX_SIDE:   side_reg   <= cfg_wdata;
                ecgmf_pkg::CFG_IDX_EDGE:   edge_reg   <= cfg_wdata;
                default: ;  // unused index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ecgmf_pkg::M_TDATA_W - ecgmf_pkg::OUT_W){1'b0}}, m_data_reg};

endmodule

// ===== test/ecg_morphological_filter_tb.sv =====
module ecg_morphological_filter_tb;

    import ecgmf_pkg::*;

    // Window sizes, kept equal to the block's defaults
    localparam int OPEN_LEN   = 25;
    localparam int CLOSE_LEN  = 37;
    localparam int NOISE_LEN  = 5;
    localparam int NOISE_MID  = (NOISE_LEN - 1) / 2;
    localparam int OPEN_LEAD  = OPEN_LEN - 1 - (OPEN_LEN - 1) / 2;
    localparam int CLOSE_LEAD = CLOSE_LEN - 1 - (CLOSE_LEN - 1) / 2;
    localparam int ALIGN_LEN  = 2 * OPEN_LEAD + 2 * CLOSE_LEAD + 1;

    // Sample counts at which each stage starts producing
    localparam int AT_OPEN_ERO  = OPEN_LEN;
    localparam int AT_OPEN_DIL  = AT_OPEN_ERO + OPEN_LEN - 1;
    localparam int AT_CLOSE_DIL = AT_OPEN_DIL + CLOSE_LEN - 1;
    localparam int AT_CLOSE_ERO = AT_CLOSE_DIL + CLOSE_LEN - 1;
    localparam int AT_BRANCH    = AT_CLOSE_ERO + NOISE_LEN - 1;
    localparam int AT_FULL      = AT_BRANCH + NOISE_LEN - 1;

    // Index past the three weight registers; writes there must be ignored
    localparam logic [CFG_AW-1:0] CFG_IDX_SPARE = 2'd3;

    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_CYC   = 200;     // beyond one full item latency
    localparam int STALL_CYC    = 3000;    // long output hold-off
    localparam int STALL_AT     = 600;     // accepted item count that starts it

    typedef logic signed [OUT_W-1:0] filtered_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    ecg_morphological_filter #(
        .OPEN_LEN  (OPEN_LEN),
        .CLOSE_LEN (CLOSE_LEN),
        .NOISE_LEN (NOISE_LEN)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [11:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [13:0] filtered
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the weights and of every line.
    // Lines are kept as queues capped at their depth, oldest item first.
    // ------------------------------------------------------------------
    weight_t w_center = CENTER_RST;
    weight_t w_side   = SIDE_RST;
    weight_t w_edge   = EDGE_RST;

    int raw_win[$];       // raw samples for the opening erosion
    int eroded_win[$];    // erosion results for the opening dilation
    int opened_win[$];    // opening results for the closing dilation
    int dilated_win[$];   // closing dilation results for the closing erosion
    int align_win[$];     // raw samples delayed to line up with the baseline
    int resid_win[$];     // residue for the weighted taps
    int upper_win[$];     // weighted dilation, flat-eroded at the end
    int lower_win[$];     // weighted erosion, flat-dilated at the end
    int seen_cnt = 0;     // saturates once the whole chain is full

    // Stimulus and expectations
    sample_t   samples_pending[$];
    filtered_t filtered_due[$];

    // Handshake bookkeeping
    logic in_hs = 1'b0;          // input item taken at the last rising edge
    int   accepted_cnt = 0;
    int   result_cnt   = 0;
    int   error_cnt    = 0;
    int   send_idle    = 20;     // percent of cycles the sender holds back
    int   recv_idle    = 69;     // percent of cycles the receiver holds back
    bit   hold_recv    = 1'b0;   // long receiver stall in progress
    int   settings_cnt = 1;

    task automatic push_win(ref int win[$], input int v, input int depth);
        win.push_back(v);
        if (win.size() > depth)
            void'(win.pop_front());
    endtask

    function automatic int win_min(input int win[$]);
        int m;
        m = win[0];
        foreach (win[k])
            if (win[k] < m)
                m = win[k];
        return m;
    endfunction

    function automatic int win_max(input int win[$]);
        int m;
        m = win[0];
        foreach (win[k])
            if (win[k] > m)
                m = win[k];
        return m;
    endfunction

    // Weight of tap j: center, the two neighbors, and everything farther out
    function automatic int tap_weight(input int j);
        int d;
        d = (j > NOISE_MID) ? j - NOISE_MID : NOISE_MID - j;
        if (d == 0)
            return int'(w_center);
        if (d == 1)
            return int'(w_side);
        return int'(w_edge);
    endfunction

    // One sample through the whole filter; emits once every line is full
    task automatic predict_filtered(input sample_t x, output bit emits,
                                    output filtered_t y);
        sample_t  eroded;
        sample_t  opened;
        sample_t  closed_dil;
        sample_t  baseline;
        residue_t resid;
        branch_t  hi;
        branch_t  lo;
        sum_t     total;
        int       a;
        int       b;
        emits = 1'b0;
        y     = '0;
        if (seen_cnt < AT_FULL)
            seen_cnt++;
        push_win(raw_win, x, OPEN_LEN);
        push_win(align_win, x, ALIGN_LEN);
        if (seen_cnt >= AT_OPEN_ERO) begin
            eroded = sample_t'(win_min(raw_win));
            push_win(eroded_win, eroded, OPEN_LEN);
        end
        if (seen_cnt >= AT_OPEN_DIL) begin
            opened = sample_t'(win_max(eroded_win));
            push_win(opened_win, opened, CLOSE_LEN);
        end
        if (seen_cnt >= AT_CLOSE_DIL) begin
            closed_dil = sample_t'(win_max(opened_win));
            push_win(dilated_win, closed_dil, CLOSE_LEN);
        end
        if (seen_cnt >= AT_CLOSE_ERO) begin
            baseline = sample_t'(win_min(dilated_win));
            resid    = residue_t'(align_win[0] - int'(baseline));
            push_win(resid_win, resid, NOISE_LEN);
        end
        if (seen_cnt >= AT_BRANCH) begin
            a = resid_win[0] + tap_weight(0);
            b = resid_win[0] - tap_weight(0);
            for (int j = 1; j < NOISE_LEN; j++) begin
                if (resid_win[j] + tap_weight(j) > a)
                    a = resid_win[j] + tap_weight(j);
                if (resid_win[j] - tap_weight(j) < b)
                    b = resid_win[j] - tap_weight(j);
            end
            hi = branch_t'(a);
            lo = branch_t'(b);
            push_win(upper_win, hi, NOISE_LEN);
            push_win(lower_win, lo, NOISE_LEN);
        end
        if (seen_cnt >= AT_FULL) begin
            total = sum_t'(win_min(upper_win) + win_max(lower_win));
            y     = filtered_t'(total / 2);    // truncates toward zero
            emits = 1'b1;
        end
    endtask

    // Register write while the block is idle; the predictor copy follows
    task automatic write_weight(input logic [CFG_AW-1:0] idx, input weight_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_IDX_CENTER: w_center = val;
            CFG_IDX_SIDE:   w_side   = val;
            CFG_IDX_EDGE:   w_edge   = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next pending sample once the current one is taken.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_hs) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, samples_pending.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    // ------------------------------------------------------------------
    // Monitor: result check first, so a fresh expectation pushed at this
    // same edge can never be matched against an unexpected result.
    // ------------------------------------------------------------------
    bit        step_emits;
    filtered_t step_y;
    filtered_t due_y;

    always @(posedge aclk) begin
        in_hs <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            result_cnt++;
            if (filtered_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, $signed(m_tdata[OUT_W-1:0]));
                error_cnt++;
            end else begin
                due_y = filtered_due.pop_front();
                if (m_tdata[OUT_W-1:0] !== due_y) begin
                    $display("%0t: filtered mismatch, expected %0d, got %0d",
                             $time, due_y, $signed(m_tdata[OUT_W-1:0]));
                    error_cnt++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted_cnt++;
            predict_filtered(sample_t'(s_tdata[SAMPLE_W-1:0]), step_emits, step_y);
            if (step_emits)
                filtered_due.push_back(step_y);
        end
    end

    // One long receiver stall while the sender keeps offering: the output
    // register and the block both fill and s_tready stays low
    initial begin
        while (accepted_cnt < STALL_AT)
            @(posedge aclk);
        hold_recv = 1'b1;
        repeat (STALL_CYC) @(posedge aclk);
        hold_recv = 1'b0;
    end

    // Timeout
    initial begin
        #12_000_000;
        $display("ecg_morphological_filter_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Phases: weights change only between phases, with the block drained.
    // ------------------------------------------------------------------
    int      drift;
    int      v;
    int      pick;
    sample_t directed[$];

    initial begin
        directed = '{-12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd1,
                     12'sh555, 12'shAAA, 12'sd2047, -12'sd2048, 12'sd2047,
                     -12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047,
                     12'sd2047, 12'sd0, 12'sd0, -12'sd1024, 12'sd1023,
                     12'sd100, -12'sd100, 12'sd2047, -12'sd2048, 12'sd0};
        drift = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Weight settings: defaults, all max (plus the spare index),
            // all zero, mixed (again with the spare index), random, and a lopsided one
            case (ph)
                1: begin
                    write_weight(CFG_IDX_CENTER, 4'd15);
                    write_weight(CFG_IDX_SIDE,   4'd15);
                    write_weight(CFG_IDX_EDGE,   4'd15);
                    write_weight(CFG_IDX_SPARE,  4'd0);
                end
                2: begin
                    write_weight(CFG_IDX_CENTER, 4'd0);
                    write_weight(CFG_IDX_SIDE,   4'd0);
                    write_weight(CFG_IDX_EDGE,   4'd0);
                end
                3: begin
                    write_weight(CFG_IDX_CENTER, 4'd0);
                    write_weight(CFG_IDX_SIDE,   4'd15);
                    write_weight(CFG_IDX_EDGE,   4'd8);
                    write_weight(CFG_IDX_SPARE,  4'd15);
                end
                4: begin
                    write_weight(CFG_IDX_CENTER, weight_t'($urandom_range(15)));
                    write_weight(CFG_IDX_SIDE,   weight_t'($urandom_range(15)));
                    write_weight(CFG_IDX_EDGE,   weight_t'($urandom_range(15)));
                end
                5: begin
                    write_weight(CFG_IDX_CENTER, 4'd15);
                    write_weight(CFG_IDX_SIDE,   4'd0);
                    write_weight(CFG_IDX_EDGE,   4'd1);
                end
                default: ;
            endcase
            if (ph > 0)
                settings_cnt++;

            // Receiver-heavy idling, then sender-heavy, then none
            send_idle = (ph < 2) ? 20 : (ph < 4) ? 69 : 0;
            recv_idle = (ph < 2) ? 69 : (ph < 4) ? 20 : 0;

            if (ph == 0)
                foreach (directed[k])
                    samples_pending.push_back(directed[k]);

            // Mostly ECG-like traces: slow baseline wander, small noise and
            // sparse tall beats; the rest is full-range noise and rail hits
            repeat ((ph == 0) ? 205 : 265) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    drift = drift + int'($urandom_range(40)) - 20;
                    if (drift > 1500)
                        drift = 1500;
                    if (drift < -1500)
                        drift = -1500;
                    v = drift + int'($urandom_range(30)) - 15;
                    if ($urandom_range(40) == 0)
                        v = v + (($urandom_range(1) != 0) ? 1800 : -1800);
                end else if (pick < 85) begin
                    v = int'($urandom_range(4095)) - 2048;
                end else begin
                    v = ($urandom_range(1) != 0) ? 2047 : -2048;
                end
                if (v > 2047)
                    v = 2047;
                if (v < -2048)
                    v = -2048;
                samples_pending.push_back(sample_t'(v));
            end

            // Sender pauses until everything is taken and every result is in
            while (samples_pending.size() != 0 || s_tvalid)
                @(posedge aclk);
            while (filtered_due.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYC) @(posedge aclk);
        end

        $display("run: %0d samples in, %0d filtered results checked, %0d mismatches",
                 accepted_cnt, result_cnt, error_cnt);
        $display("run: %0d weight settings incl. extremes, %0d-cycle output stall",
                 settings_cnt, STALL_CYC);
        if (error_cnt == 0)
            $display("ecg_morphological_filter_tb OK");
        else
            $display("ecg_morphological_filter_tb NOT OK");
        $finish;
    end

endmodule
